[sv/mpsa_pkg.sv]
package mpsa_pkg;

  // Result status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_DOUBLE = 2'd2;

  // Widths of the request and result words.
  localparam int IDX_W    = 6;
  localparam int POOL_W   = 2;
  localparam int STATUS_W = 2;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic commit;
    logic release_op;
  } cell_ctrl_t;

endpackage

[sv/mpsa_cell.sv]
module mpsa_cell #(
  parameter int IDX   = 0,
  parameter int POOLS = 4,
  parameter int EW    = 6,
  parameter int HW    = 7,
  parameter int PW    = 2
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mpsa_pkg::cell_ctrl_t           ctrl,
  input  logic [PW-1:0]                  pool_sel,
  input  logic [HW-1:0]                  head,
  input  logic [mpsa_pkg::IDX_W-1:0]     idx,
  input  logic                           found_in,
  input  logic [EW-1:0]                  data_in,
  input  logic [EW-1:0]                  next_entry,
  output logic                           found_out_r,
  output logic [EW-1:0]                  data_out_r,
  output logic [EW-1:0]                  entry_out
);
  import mpsa_pkg::*;

  localparam int CW = (EW > IDX_W) ? EW : IDX_W;

  logic [EW-1:0] entry_r [POOLS];
  logic          in_use;
  logic          match;
  logic          found_incl;

  assign entry_out  = entry_r[pool_sel];
  assign in_use     = HW'(IDX) < head;
  assign match      = in_use && (CW'(entry_out) == CW'(idx));
  // This cell lies at or past the released entry.
  assign found_incl = found_in | match;

  // The found flag and the entry at the head position ripple one cell a cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_out_r <= 1'b0;
    end else begin
      found_out_r <= found_incl;
    end
  end

  always_ff @(posedge clk) begin
    data_out_r <= (HW'(IDX) == head) ? entry_out : data_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < POOLS; p++) begin
        entry_r[p] <= EW'(IDX);
      end
    end else if (ctrl.commit && ctrl.release_op && found_incl) begin
      if (HW'(IDX + 1) < head) begin
        entry_r[pool_sel] <= next_entry;
      end else if (HW'(IDX + 1) == head) begin
        entry_r[pool_sel] <= EW'(idx);
      end
    end
  end

endmodule

[sv/multi_pool_slot_allocator.sv]
// Channel   Ports                                        Handshake
// input     in_mode, in_pool, in_slot_index              start, busy
// result    out_status, out_granted_index                out_valid strobe
//
// Every word passes from acceptance through the sweep, while the found flag
// and the head entry travel down the row of cells, the commit of the shift,
// and the result cycle, in which a new word may already be taken; no new word
// is accepted while busy. Reset is synchronous; afterwards every
// list is in identity order and all heads are zero. The receiver cannot
// stall; each result is shown for exactly one cycle.
module multi_pool_slot_allocator #(
  parameter int POOLS = 4,
  parameter int SLOTS = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_mode,
  input  logic [mpsa_pkg::POOL_W-1:0]        in_pool,
  input  logic [mpsa_pkg::IDX_W-1:0]         in_slot_index,
  output logic                               out_valid,
  output logic [mpsa_pkg::STATUS_W-1:0]      out_status,
  output logic [mpsa_pkg::IDX_W-1:0]         out_granted_index
);
  import mpsa_pkg::*;

  localparam int EW   = $clog2(SLOTS);
  localparam int HW   = $clog2(SLOTS + 1);
  localparam int PW   = (POOLS > 1) ? $clog2(POOLS) : 1;
  localparam int CNTW = $clog2(SLOTS);

  typedef enum logic [1:0] {
    IDLE,
    SWEEP,
    COMMIT
  } state_t;

  state_t                state_r;
  logic [CNTW-1:0]       cnt_r;
  logic                  mode_r;
  logic                  pool_ok_r;
  logic [PW-1:0]         pool_sel_r;
  logic [IDX_W-1:0]      idx_r;
  logic [HW-1:0]         head_q_r;
  logic [HW-1:0]         head_r [POOLS];
  logic                  out_valid_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [IDX_W-1:0]      out_granted_index_r;

  logic                  accept;
  cell_ctrl_t            ctrl;
  logic                  found_w [SLOTS+1];
  logic [EW-1:0]         data_w  [SLOTS+1];
  logic [EW-1:0]         ent_w   [SLOTS+1];

  assign busy              = (state_r != IDLE);
  assign accept            = start && !busy;
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_granted_index = out_granted_index_r;

  assign ctrl.commit     = (state_r == COMMIT) && pool_ok_r;
  assign ctrl.release_op = mode_r;

  assign found_w[0]  = 1'b0;
  assign data_w[0]   = '0;
  assign ent_w[SLOTS] = '0;

  for (genvar j = 0; j < SLOTS; j++) begin : g_cell
    mpsa_cell #(
      .IDX   (j),
      .POOLS (POOLS),
      .EW    (EW),
      .HW    (HW),
      .PW    (PW)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .pool_sel    (pool_sel_r),
      .head        (head_q_r),
      .idx         (idx_r),
      .found_in    (found_w[j]),
      .data_in     (data_w[j]),
      .next_entry  (ent_w[j+1]),
      .found_out_r (found_w[j+1]),
      .data_out_r  (data_w[j+1]),
      .entry_out   (ent_w[j])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      for (int p = 0; p < POOLS; p++) begin
        head_r[p] <= '0;
      end
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        IDLE: begin
          if (accept) begin
            mode_r     <= in_mode;
            pool_ok_r  <= int'(in_pool) < POOLS;
            pool_sel_r <= PW'(in_pool);
            idx_r      <= in_slot_index;
            head_q_r   <= head_r[PW'(in_pool)];
            cnt_r      <= '0;
            state_r    <= SWEEP;
          end
        end
        SWEEP: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNTW'(SLOTS - 1)) begin
            state_r <= COMMIT;
          end
        end
        COMMIT: begin
          out_valid_r         <= 1'b1;
          out_granted_index_r <= '0;
          state_r             <= IDLE;
          if (!pool_ok_r) begin
            out_status_r <= mode_r ? ST_DOUBLE : ST_FULL;
          end else if (!mode_r) begin
            if (head_q_r >= HW'(SLOTS)) begin
              out_status_r <= ST_FULL;
            end else begin
              out_status_r          <= ST_OK;
              out_granted_index_r   <= IDX_W'(data_w[SLOTS]);
              head_r[pool_sel_r]    <= head_q_r + 1'b1;
            end
          end else if (found_w[SLOTS]) begin
            out_status_r       <= ST_OK;
            head_r[pool_sel_r] <= head_q_r - 1'b1;
          end else begin
            out_status_r <= ST_DOUBLE;
          end
        end
        default: begin
          state_r <= IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_result_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == COMMIT))
    else $error("result strobe without a commit cycle");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("block not busy after accepting a word");

  a_head_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> head_q_r <= HW'(SLOTS))
    else $error("pool head beyond the list length");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_FULL ||
                   out_status == ST_DOUBLE))
    else $error("undefined status code");

  a_grant_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_granted_index == '0)
    else $error("index granted on a failed request");
`endif

endmodule
